>>> sv/e2r_pkg.sv
`timescale 1ns / 1ps

package e2r_pkg;

   localparam int ANGLE_BITS_DEF    = 16;
   localparam int OUT_FRAC_BITS_DEF = 14;
   localparam int Q_W               = 34;
   localparam int HORNER_STEPS      = 4;

   localparam logic signed [Q_W-1:0] Q30_ONE = 34'sd1073741824;
   localparam logic signed [Q_W-1:0] CF_A9   = 34'sd172272;

   // Horner constants, innermost first: -A7, A5, -A3, A1
   localparam logic signed [Q_W-1:0] HORNER_COEF [HORNER_STEPS] = '{
      -34'sd5026995, 34'sd85569306, -34'sd693598669, 34'sd1686629713
   };

   // Data handed from one polynomial cell to the next
   typedef struct packed {
      logic signed [Q_W-1:0] t;
      logic signed [Q_W-1:0] x2;
      logic        [30:0]    x;
      logic                  neg;
   } e2r_lane_type;

   // Q30 product, rounded half away from zero
   function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
      logic        neg;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] p;
      logic [33:0] r;
      neg = a[Q_W-1] ^ b[Q_W-1];
      ma  = a[Q_W-1] ? 32'(-a) : 32'(a);
      mb  = b[Q_W-1] ? 32'(-b) : 32'(b);
      p   = ({32'd0, ma} * {32'd0, mb}) + 64'd536870912;
      r   = p[63:30];
      return neg ? -$signed(r) : $signed(r);
   endfunction

endpackage

>>> sv/e2r_horner_cell.sv
`timescale 1ns / 1ps

module e2r_horner_cell #(
   parameter int K = 0
) (
   input  logic                   clock,
   input  logic                   adv,
   input  e2r_pkg::e2r_lane_type  prev_lane,
   output e2r_pkg::e2r_lane_type  next_lane
);

   e2r_pkg::e2r_lane_type lane_in;
   e2r_pkg::e2r_lane_type lane_ff;

   // Fold in one coefficient: t = c + t * x^2
   always_comb begin
      lane_in   = prev_lane;
      lane_in.t = e2r_pkg::HORNER_COEF[K] + e2r_pkg::qmul(prev_lane.t, prev_lane.x2);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

>>> sv/e2r_sine_lane.sv
`timescale 1ns / 1ps

module e2r_sine_lane #(
   parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
   parameter bit COS        = 1'b0
) (
   input  logic                               clock,
   input  logic                               adv,
   input  logic [ANGLE_BITS-1:0]              angle,
   output logic signed [e2r_pkg::Q_W-1:0]     sine
);

   logic [ANGLE_BITS+31:0]   wide_ph;
   logic [31:0]              phase;
   logic [30:0]              x_in;
   logic [30:0]              x_ff;
   logic                     neg_ff;
   e2r_pkg::e2r_lane_type    head_in;
   e2r_pkg::e2r_lane_type    head_ff;
   e2r_pkg::e2r_lane_type    chain [e2r_pkg::HORNER_STEPS+1];
   logic signed [e2r_pkg::Q_W-1:0] poly;
   logic signed [e2r_pkg::Q_W-1:0] clamp;
   logic signed [e2r_pkg::Q_W-1:0] sine_in;
   logic signed [e2r_pkg::Q_W-1:0] sine_ff;

   // Left-align the angle to a 32-bit phase, shift a quarter turn for cosine
   always_comb begin
      wide_ph = {angle, 32'd0} >> ANGLE_BITS;
      phase   = wide_ph[31:0] + (COS ? 32'h4000_0000 : 32'h0000_0000);
      x_in    = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         neg_ff <= phase[31];
      end
   end

   // Square the quarter-wave argument
   always_comb begin
      head_in.x   = x_ff;
      head_in.neg = neg_ff;
      head_in.x2  = e2r_pkg::qmul($signed({3'b000, x_ff}), $signed({3'b000, x_ff}));
      head_in.t   = e2r_pkg::CF_A9;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   // Row of polynomial cells
   for (genvar k = 0; k < e2r_pkg::HORNER_STEPS; k++) begin : g_cell
      e2r_horner_cell #(.K(k)) u_cell (
         .clock     (clock),
         .adv       (adv),
         .prev_lane (chain[k]),
         .next_lane (chain[k+1])
      );
   end

   // Final multiply by x, clamp to [0, 1] and apply the quadrant sign
   always_comb begin
      poly = e2r_pkg::qmul(chain[e2r_pkg::HORNER_STEPS].t,
                           $signed({3'b000, chain[e2r_pkg::HORNER_STEPS].x}));
      priority if (poly < 0) begin
         clamp = '0;
      end else if (poly > e2r_pkg::Q30_ONE) begin
         clamp = e2r_pkg::Q30_ONE;
      end else begin
         clamp = poly;
      end
      sine_in = chain[e2r_pkg::HORNER_STEPS].neg ? -clamp : clamp;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

>>> sv/euler_to_rotation_matrix.sv
`timescale 1ns / 1ps

// Euler (yaw-pitch-roll, ZYX) angles to 3x3 rotation matrix.
// Request channel: req_valid / req_stall with pitch, roll and yaw as signed
// binary angles, 2^ANGLE_BITS per full turn; any bit pattern is a valid angle.
// Response channel: rsp_valid / rsp_stall with the nine matrix entries as
// signed fixed point, OUT_FRAC_BITS fraction bits, saturated to +/-1.
// An accepted request's response passes through seven stages of sine/cosine
// polynomial (one Horner step per cell), two product stages and one
// rounding/saturation stage, which is also the output register.
// Throughput is one request per cycle; all stages advance together.
// When the response is valid and stalled, the whole pipeline holds and
// req_stall is raised, so no request is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; data in flight is
// dropped and the block accepts a request in the first cycle after reset.
module euler_to_rotation_matrix #(
   parameter int ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF,
   parameter int OUT_FRAC_BITS = e2r_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ANGLE_BITS-1:0]  req_pitch_angle,
   input  logic signed [ANGLE_BITS-1:0]  req_roll_angle,
   input  logic signed [ANGLE_BITS-1:0]  req_yaw_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r0c0,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r0c1,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r0c2,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r1c0,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r1c1,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r1c2,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r2c0,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r2c1,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_m_r2c2
);

   localparam int QW    = e2r_pkg::Q_W;
   localparam int OW    = OUT_FRAC_BITS + 2;
   localparam int DEPTH = 10;
   localparam int SH    = 30 - OUT_FRAC_BITS;
   localparam logic [QW-1:0] RND = (SH > 0) ? (QW'(1) << (SH - 1)) : '0;
   localparam logic [QW-1:0] LIM = QW'(1) << OUT_FRAC_BITS;

   typedef logic signed [QW-1:0] q_type;

   logic [DEPTH-1:0] vld_in;
   logic [DEPTH-1:0] vld_ff;
   logic             adv;

   q_type sp, cp, sr, cr, sy, cy;

   q_type spcy_ff, spsy_ff, cpcy_ff, cpsy_ff, srsy_ff, crsy_ff;
   q_type crcy_ff, srcy_ff, srcp_ff, crcp_ff, sr_ff, cr_ff, sp_ff;

   q_type a1_ff, a2_ff, a3_ff, a4_ff;
   q_type b_cpcy_ff, b_cpsy_ff, b_srsy_ff, b_crsy_ff, b_crcy_ff, b_srcy_ff;
   q_type b_srcp_ff, b_crcp_ff, b_sp_ff;

   logic signed [OW-1:0] m_ff [9];

   // Round Q30 to the output format and saturate to +/-1
   function automatic logic signed [OW-1:0] to_out(input q_type v);
      logic [QW-1:0] m;
      logic [QW-1:0] r;
      m = v[QW-1] ? QW'(-v) : QW'(v);
      r = (m + RND) >> SH;
      if (r > LIM) begin
         r = LIM;
      end
      return v[QW-1] ? OW'(-r) : OW'(r);
   endfunction

   // Advance unless the finished response is held back
   assign adv       = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[DEPTH-1];
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Sine and cosine lanes
   e2r_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COS(1'b0)) u_sp (
      .clock(clock), .adv(adv), .angle(req_pitch_angle), .sine(sp));
   e2r_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COS(1'b1)) u_cp (
      .clock(clock), .adv(adv), .angle(req_pitch_angle), .sine(cp));
   e2r_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COS(1'b0)) u_sr (
      .clock(clock), .adv(adv), .angle(req_roll_angle), .sine(sr));
   e2r_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COS(1'b1)) u_cr (
      .clock(clock), .adv(adv), .angle(req_roll_angle), .sine(cr));
   e2r_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COS(1'b0)) u_sy (
      .clock(clock), .adv(adv), .angle(req_yaw_angle), .sine(sy));
   e2r_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COS(1'b1)) u_cy (
      .clock(clock), .adv(adv), .angle(req_yaw_angle), .sine(cy));

   // First products
   always_ff @(posedge clock) begin
      if (adv) begin
         spcy_ff <= e2r_pkg::qmul(sp, cy);
         spsy_ff <= e2r_pkg::qmul(sp, sy);
         cpcy_ff <= e2r_pkg::qmul(cp, cy);
         cpsy_ff <= e2r_pkg::qmul(cp, sy);
         srsy_ff <= e2r_pkg::qmul(sr, sy);
         crsy_ff <= e2r_pkg::qmul(cr, sy);
         crcy_ff <= e2r_pkg::qmul(cr, cy);
         srcy_ff <= e2r_pkg::qmul(sr, cy);
         srcp_ff <= e2r_pkg::qmul(sr, cp);
         crcp_ff <= e2r_pkg::qmul(cr, cp);
         sr_ff   <= sr;
         cr_ff   <= cr;
         sp_ff   <= sp;
      end
   end

   // Second products on the pitch-yaw terms
   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff     <= e2r_pkg::qmul(sr_ff, spcy_ff);
         a2_ff     <= e2r_pkg::qmul(cr_ff, spcy_ff);
         a3_ff     <= e2r_pkg::qmul(sr_ff, spsy_ff);
         a4_ff     <= e2r_pkg::qmul(cr_ff, spsy_ff);
         b_cpcy_ff <= cpcy_ff;
         b_cpsy_ff <= cpsy_ff;
         b_srsy_ff <= srsy_ff;
         b_crsy_ff <= crsy_ff;
         b_crcy_ff <= crcy_ff;
         b_srcy_ff <= srcy_ff;
         b_srcp_ff <= srcp_ff;
         b_crcp_ff <= crcp_ff;
         b_sp_ff   <= sp_ff;
      end
   end

   // Sum, round and saturate into the output register
   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0] <= to_out(b_cpcy_ff);
         m_ff[1] <= to_out(a1_ff - b_crsy_ff);
         m_ff[2] <= to_out(a2_ff + b_srsy_ff);
         m_ff[3] <= to_out(b_cpsy_ff);
         m_ff[4] <= to_out(a3_ff + b_crcy_ff);
         m_ff[5] <= to_out(a4_ff - b_srcy_ff);
         m_ff[6] <= to_out(-b_sp_ff);
         m_ff[7] <= to_out(b_srcp_ff);
         m_ff[8] <= to_out(b_crcp_ff);
      end
   end

   assign rsp_m_r0c0 = m_ff[0];
   assign rsp_m_r0c1 = m_ff[1];
   assign rsp_m_r0c2 = m_ff[2];
   assign rsp_m_r1c0 = m_ff[3];
   assign rsp_m_r1c1 = m_ff[4];
   assign rsp_m_r1c2 = m_ff[5];
   assign rsp_m_r2c0 = m_ff[6];
   assign rsp_m_r2c1 = m_ff[7];
   assign rsp_m_r2c2 = m_ff[8];

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_pitch_angle = '0;
   logic signed [15:0] req_roll_angle = '0;
   logic signed [15:0] req_yaw_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_m [9];

   matrix_type expected_matrices [$];
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_off_cycles = 0;
   int unsigned mismatches = 0;
   longint unsigned cycle_count = 0;

   euler_to_rotation_matrix dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pitch_angle(req_pitch_angle), .req_roll_angle(req_roll_angle),
      .req_yaw_angle(req_yaw_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_m_r0c0(rsp_m[0]), .rsp_m_r0c1(rsp_m[1]), .rsp_m_r0c2(rsp_m[2]),
      .rsp_m_r1c0(rsp_m[3]), .rsp_m_r1c1(rsp_m[4]), .rsp_m_r1c2(rsp_m[5]),
      .rsp_m_r2c0(rsp_m[6]), .rsp_m_r2c1(rsp_m[7]), .rsp_m_r2c2(rsp_m[8])
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Q30 product, rounded half away from zero
   function automatic longint q30_mul(longint a, longint b);
      logic neg;
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned p;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = (ma * mb + (64'd1 << 29)) >> 30;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint quarter_wave(longint x);
      longint x2;
      longint t;
      x2 = q30_mul(x, x);
      t = 172272;
      t = -5026995 + q30_mul(t, x2);
      t = 85569306 + q30_mul(t, x2);
      t = -693598669 + q30_mul(t, x2);
      t = 1686629713 + q30_mul(t, x2);
      t = q30_mul(t, x);
      if (t < 0) t = 0;
      if (t > 64'sd1073741824) t = 1073741824;
      return t;
   endfunction

   function automatic longint sine_of_phase(logic [31:0] phase);
      longint frac;
      longint s;
      frac = longint'(phase[29:0]);
      s = phase[30] ? quarter_wave(64'sd1073741824 - frac) : quarter_wave(frac);
      return phase[31] ? -s : s;
   endfunction

   // Round Q30 to Q1.14 and saturate to +/-1
   function automatic logic signed [15:0] to_q14(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (1 << 15)) >> 16;
      if (m > 16384) m = 16384;
      return (v < 0) ? 16'(-m) : 16'(m);
   endfunction

   function automatic matrix_type rotation_of(logic [15:0] p, logic [15:0] r,
                                              logic [15:0] y);
      matrix_type res;
      longint sp, cp, sr, cr, sy, cy, spcy, spsy;
      sp = sine_of_phase({p, 16'd0});
      cp = sine_of_phase({p, 16'd0} + 32'h4000_0000);
      sr = sine_of_phase({r, 16'd0});
      cr = sine_of_phase({r, 16'd0} + 32'h4000_0000);
      sy = sine_of_phase({y, 16'd0});
      cy = sine_of_phase({y, 16'd0} + 32'h4000_0000);
      spcy = q30_mul(sp, cy);
      spsy = q30_mul(sp, sy);
      res.m[0] = to_q14(q30_mul(cp, cy));
      res.m[1] = to_q14(q30_mul(sr, spcy) - q30_mul(cr, sy));
      res.m[2] = to_q14(q30_mul(cr, spcy) + q30_mul(sr, sy));
      res.m[3] = to_q14(q30_mul(cp, sy));
      res.m[4] = to_q14(q30_mul(sr, spsy) + q30_mul(cr, cy));
      res.m[5] = to_q14(q30_mul(cr, spsy) - q30_mul(sr, cy));
      res.m[6] = to_q14(-sp);
      res.m[7] = to_q14(q30_mul(sr, cp));
      res.m[8] = to_q14(q30_mul(cr, cp));
      return res;
   endfunction

   // Send one request, holding it until accepted; valid stays up for the next one
   task automatic send_angles(logic [15:0] p, logic [15:0] r, logic [15:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pitch_angle <= p;
      req_roll_angle <= r;
      req_yaw_angle <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_matrices.push_back(rotation_of(p, r, y));
      @(negedge clock);
   endtask

   // Drive the response stall: long hold-off first, else random
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      matrix_type exp_m;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matrices.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected response at cycle %0d", cycle_count);
         end else begin
            exp_m = expected_matrices.pop_front();
            for (int i = 0; i < 9; i++) begin
               if (rsp_m[i] !== exp_m.m[i]) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("entry %0d: expected %0d, got %0d", i, exp_m.m[i], rsp_m[i]);
               end
            end
         end
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Drop valid and wait until every request has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_matrices.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [15:0] corners [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                   16'h7FFF, 16'h0001, 16'hFFFF, 16'h2000};
      foreach (corners[i]) send_angles(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_angles(16'h5555, 16'hAAAA, 16'h1234);
      send_angles(16'hAAAA, 16'h5555, 16'hEDCB);
      drain();
   endtask

   task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (n) send_angles(16'($urandom), 16'($urandom), 16'($urandom));
      drain();
   endtask

   // Hold the response side off long enough that the pipeline fills
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 60;
      repeat (40) send_angles(16'($urandom), 16'($urandom), 16'($urandom));
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400, 0, 0);
      test_random(400, 59, 0);
      test_random(400, 0, 59);
      test_random(400, 18, 18);
      test_backpressure();
      test_random(100, 0, 0);
      if (mismatches == 0 && expected_matrices.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
